// ----- rtl/ccrn_pkg.sv -----
// shared types and constants of the cross-channel response normalizer
// used by ccrn_norm and the top level; depends on nothing
`default_nettype none
package ccrn_pkg;

  localparam int RING_DEPTH = 32;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int MAX_OUT    = 16;
  localparam int COUNT_W    = RING_AW + 8;
  localparam int HALF_LIM_A = (RING_DEPTH - 1) / 2;
  localparam int HALF_MAX   = (HALF_LIM_A < MAX_OUT - 1) ? HALF_LIM_A : MAX_OUT - 1;
  localparam int SQ_W       = 48;
  localparam int WSUM_W     = 53;
  localparam int M_W        = 54;
  localparam int SMP_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_K      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA        = 3'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normalized;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] sample;
    logic [M_W-1:0]     mag_sum;
    logic [15:0]        beta;
  } norm_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [15:0] result;
  } norm_sts_t;

endpackage
`default_nettype wire

// ----- rtl/ccrn_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none
module ccrn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/ccrn_norm.sv -----
// power unit: sample * m^-beta through log2, a scaled multiply and exp2
// depends on ccrn_pkg
`default_nettype none
module ccrn_norm import ccrn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire norm_req_t req,
  output norm_sts_t      sts
);
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef enum logic [3:0] {
    N_IDLE, N_LZC, N_LOG, N_EMUL, N_SPLIT, N_XMUL, N_TA, N_TB, N_TC, N_PMUL, N_SHIFT
  } nstate_t;

  // floor(2^36 / i) for the taylor term divisors
  function automatic logic [36:0] recip(input logic [4:0] i);
    logic [36:0] v;
    case (i)
      5'd1:    v = 37'd68719476736;
      5'd2:    v = 37'd34359738368;
      5'd3:    v = 37'd22906492245;
      5'd4:    v = 37'd17179869184;
      5'd5:    v = 37'd13743895347;
      5'd6:    v = 37'd11453246122;
      5'd7:    v = 37'd9817068105;
      5'd8:    v = 37'd8589934592;
      5'd9:    v = 37'd7635497415;
      5'd10:   v = 37'd6871947673;
      5'd11:   v = 37'd6247225157;
      5'd12:   v = 37'd5726623061;
      5'd13:   v = 37'd5286113595;
      5'd14:   v = 37'd4908534052;
      5'd15:   v = 37'd4581298449;
      5'd16:   v = 37'd4294967296;
      default: v = 37'd0;
    endcase
    return v;
  endfunction

  nstate_t            state_r;
  logic               done_r;
  logic signed [15:0] res_r;
  logic               neg_r;
  logic [15:0]        mag_r;
  logic [15:0]        beta_r;
  logic [63:0]        nrm_r;
  logic [5:0]         shc_r;
  logic [2:0]         step_r;
  logic [30:0]        u_r;
  logic signed [6:0]  lgi_r;
  logic [29:0]        lgf_r;
  logic [4:0]         it_r;
  logic signed [54:0] e44_r;
  logic signed [10:0] n_r;
  logic [29:0]        f_r;
  logic [29:0]        x_r;
  logic [30:0]        term_r;
  logic [31:0]        sum_r;
  logic [29:0]        t_r;
  logic [29:0]        q0_r;
  logic [4:0]         i_r;
  logic [47:0]        prod_r;

  // leading-zero step
  logic [6:0]  lz_w;
  logic [63:0] lz_mask;
  logic [63:0] nrm_nxt;
  logic [5:0]  shc_nxt;
  always_comb begin
    lz_w    = 7'd1 << step_r;
    lz_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> lz_w);
    if ((nrm_r & lz_mask) == 64'd0) begin
      nrm_nxt = nrm_r << lz_w;
      shc_nxt = shc_r + lz_w[5:0];
    end else begin
      nrm_nxt = nrm_r;
      shc_nxt = shc_r;
    end
  end

  // squaring step of the mantissa log
  logic [61:0] usq;
  logic [31:0] usq_hi;
  assign usq    = {31'd0, u_r} * {31'd0, u_r};
  assign usq_hi = usq[61:30];

  logic signed [36:0] lg;
  logic signed [54:0] bl;
  assign lg = {lgi_r, lgf_r};
  assign bl = $signed({1'b0, beta_r}) * lg;

  logic signed [40:0] e30;
  assign e30 = 41'(e44_r >>> 14);

  logic [59:0] fx;
  assign fx = f_r * LN2_Q30;

  logic [60:0] tx;
  assign tx = term_r * x_r;

  logic [66:0] tr;
  assign tr = t_r * recip(i_r);

  logic [34:0] qi;
  logic [34:0] chk;
  logic [29:0] q;
  always_comb begin
    qi  = q0_r * i_r;
    chk = {5'd0, t_r} - qi;
    q   = (chk >= {30'd0, i_r}) ? q0_r + 30'd1 : q0_r;
  end

  // final rounding shift and saturation
  logic signed [11:0] shs;
  logic [5:0]         sh;
  logic [63:0]        rnd;
  logic signed [15:0] fin;
  always_comb begin
    shs = 12'sd30 - 12'(n_r);
    sh  = shs[5:0];
    if (shs == 12'sd0) begin
      rnd = {16'd0, prod_r};
    end else if (shs >= 12'sd49) begin
      rnd = 64'd0;
    end else begin
      rnd = ({16'd0, prod_r} + (64'd1 << (sh - 6'd1))) >> sh;
    end
    if (!neg_r) begin
      fin = (rnd > 64'd32767) ? 16'sd32767 : 16'(rnd);
    end else begin
      fin = (rnd > 64'd32768) ? -16'sd32768 : -16'(rnd);
    end
  end

  logic signed [15:0] sat_val;
  assign sat_val = req.sample[15] ? -16'sd32768 : 16'sd32767;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (req.start) begin
            neg_r  <= req.sample[15];
            mag_r  <= req.sample[15] ? 16'(-req.sample) : req.sample;
            beta_r <= req.beta;
            if (req.sample == 16'sd0) begin
              res_r  <= 16'sd0;
              done_r <= 1'b1;
            end else if (req.mag_sum == '0) begin
              res_r  <= (req.beta == 16'd0) ? req.sample : sat_val;
              done_r <= 1'b1;
            end else begin
              nrm_r   <= {10'd0, req.mag_sum};
              shc_r   <= 6'd0;
              step_r  <= 3'd5;
              state_r <= N_LZC;
            end
          end
        end
        N_LZC: begin
          nrm_r  <= nrm_nxt;
          shc_r  <= shc_nxt;
          step_r <= step_r - 3'd1;
          if (step_r == 3'd0) begin
            u_r     <= nrm_nxt[63:33];
            lgi_r   <= 7'sd29 - $signed({1'b0, shc_nxt});
            lgf_r   <= 30'd0;
            it_r    <= 5'd0;
            state_r <= N_LOG;
          end
        end
        N_LOG: begin
          if (usq_hi[31]) begin
            u_r   <= usq_hi[31:1];
            lgf_r <= {lgf_r[28:0], 1'b1};
          end else begin
            u_r   <= usq_hi[30:0];
            lgf_r <= {lgf_r[28:0], 1'b0};
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'd29) begin
            state_r <= N_EMUL;
          end
        end
        N_EMUL: begin
          e44_r   <= -bl;
          state_r <= N_SPLIT;
        end
        N_SPLIT: begin
          n_r <= e30[40:30];
          f_r <= e30[29:0];
          if ($signed(e30[40:30]) >= 11'sd31) begin
            res_r   <= neg_r ? -16'sd32768 : 16'sd32767;
            done_r  <= 1'b1;
            state_r <= N_IDLE;
          end else begin
            state_r <= N_XMUL;
          end
        end
        N_XMUL: begin
          x_r     <= fx[59:30];
          term_r  <= 31'h4000_0000;
          sum_r   <= 32'h4000_0000;
          i_r     <= 5'd1;
          state_r <= N_TA;
        end
        N_TA: begin
          t_r     <= tx[59:30];
          state_r <= N_TB;
        end
        N_TB: begin
          q0_r    <= tr[65:36];
          state_r <= N_TC;
        end
        N_TC: begin
          term_r <= {1'b0, q};
          sum_r  <= sum_r + {2'd0, q};
          i_r    <= i_r + 5'd1;
          state_r <= (i_r == 5'd16) ? N_PMUL : N_TA;
        end
        N_PMUL: begin
          prod_r  <= mag_r * sum_r;
          state_r <= N_SHIFT;
        end
        N_SHIFT: begin
          res_r   <= fin;
          done_r  <= 1'b1;
          state_r <= N_IDLE;
        end
        default: begin
          state_r <= N_IDLE;
        end
      endcase
    end
  end

  assign sts.busy   = (state_r != N_IDLE);
  assign sts.done   = done_r;
  assign sts.result = res_r;
endmodule
`default_nettype wire

// ----- rtl/cross_channel_response_normalizer_unit.sv -----
// cross-channel response normalizer top level: rings, window sum, sequencing
// depends on ccrn_pkg, ccrn_ram, ccrn_norm
//
//   channel  | ports                        | meaning
//   in_      | in_valid in_ready in_data    | one channel sample, last marked
//   out_     | out_valid out_ready out_data | one normalized channel, last marked
//   cfg_     | cfg_wr_en cfg_index cfg_wdata| register write, no wait
//
// an item's scaled square takes two multiplies and a 48-bit divide by the
// window size at 4 quotient bits a cycle
// each result then passes through the power unit: 30 mantissa squarings
// and 16 taylor terms, each a multiply, a reciprocal multiply and a rounding fix
// the output register lets the next item in while a result is still waiting
// synchronous reset; ring memories need no clearing pass
`default_nettype none
module cross_channel_response_normalizer_unit import ccrn_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SCALE, S_DIV, S_WRITE, S_DECIDE, S_READ, S_START, S_WAIT, S_OUT
  } state_t;

  state_t              state_r;
  logic [4:0]          ws_r;
  logic [23:0]         bias_r;
  logic [31:0]         alpha_r;
  logic [15:0]         beta_r;
  logic signed [15:0]  smp_r;
  logic                last_r;
  logic [30:0]         mag2_r;
  logic [SQ_W-1:0]     dq_r;
  logic [4:0]          rem_r;
  logic [3:0]          dcnt_r;
  logic [WSUM_W-1:0]   wsum_r;
  logic [COUNT_W-1:0]  arr_r;
  logic [COUNT_W-1:0]  emt_r;
  logic [5:0]          terms_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [4:0] eff_ws;
  logic [3:0] half;
  assign eff_ws = (ws_r == 5'd0) ? 5'd1 : ws_r;
  assign half   = (eff_ws[4:1] > 4'(HALF_MAX)) ? 4'(HALF_MAX) : eff_ws[4:1];

  logic [15:0] mag;
  assign mag = smp_r[15] ? 16'(-smp_r) : smp_r;

  logic [62:0] scaled;
  assign scaled = mag2_r * alpha_r;

  // four restoring divide steps per cycle
  logic [SQ_W-1:0] dq_nxt;
  logic [4:0]      rem_nxt;
  logic [5:0]      trial;
  always_comb begin
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    for (int b = 0; b < 4; b++) begin
      trial = {rem_nxt, dq_nxt[SQ_W-1]};
      if (trial >= {1'b0, eff_ws}) begin
        trial  = trial - {1'b0, eff_ws};
        dq_nxt = {dq_nxt[SQ_W-2:0], 1'b1};
      end else begin
        dq_nxt = {dq_nxt[SQ_W-2:0], 1'b0};
      end
      rem_nxt = trial[4:0];
    end
  end

  logic [COUNT_W-1:0] gap;
  logic               drop_old;
  assign gap      = arr_r - emt_r;
  assign drop_old = ({{(COUNT_W-6){1'b0}}, terms_r} == gap + COUNT_W'(half));

  logic [RING_AW-1:0] old_slot;
  assign old_slot = emt_r[RING_AW-1:0] - RING_AW'(half);

  logic                smp_rd;
  logic [SQ_W-1:0]     sq_rd;
  logic [SMP_W-1:0]    smp_rd_data;
  logic                ram_we;
  logic                ram_re;
  assign ram_we = (state_r == S_WRITE);
  assign ram_re = (state_r == S_READ);

  ccrn_ram #(.WIDTH(SMP_W), .DEPTH(RING_DEPTH)) u_sample_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (arr_r[RING_AW-1:0]),
    .wdata (smp_r),
    .re    (ram_re),
    .raddr (emt_r[RING_AW-1:0]),
    .rdata (smp_rd_data)
  );

  ccrn_ram #(.WIDTH(SQ_W), .DEPTH(RING_DEPTH)) u_square_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (arr_r[RING_AW-1:0]),
    .wdata (dq_r),
    .re    (ram_re),
    .raddr (old_slot),
    .rdata (sq_rd)
  );

  norm_req_t nreq;
  norm_sts_t nsts;
  assign nreq.start   = (state_r == S_START);
  assign nreq.sample  = smp_rd_data;
  assign nreq.mag_sum = {12'd0, bias_r, 18'd0} + {1'b0, wsum_r};
  assign nreq.beta    = beta_r;

  ccrn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .sts   (nsts)
  );

  assign smp_rd = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= 5'd5;
      bias_r      <= 24'd131072;
      alpha_r     <= 32'd429497;
      beta_r      <= 16'd12288;
      wsum_r      <= '0;
      arr_r       <= '0;
      emt_r       <= '0;
      terms_r     <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !smp_rd) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            smp_r   <= in_data.sample;
            last_r  <= in_data.last_channel;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          mag2_r  <= {15'd0, mag} * {15'd0, mag};
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          dq_r    <= scaled[61:14];
          rem_r   <= 5'd0;
          dcnt_r  <= 4'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dq_r   <= dq_nxt;
          rem_r  <= rem_nxt;
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'(SQ_W / 4 - 1)) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          wsum_r  <= wsum_r + {{(WSUM_W-SQ_W){1'b0}}, dq_r};
          terms_r <= terms_r + 6'd1;
          arr_r   <= arr_r + COUNT_W'(1);
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (last_r) begin
            if (gap != '0) begin
              state_r <= S_READ;
            end else begin
              // pixel done: start the next one clean
              wsum_r  <= '0;
              arr_r   <= '0;
              emt_r   <= '0;
              terms_r <= '0;
              state_r <= S_IDLE;
            end
          end else if (gap > COUNT_W'(half)) begin
            state_r <= S_READ;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_READ: begin
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (nsts.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (smp_rd) begin
            out_r.normalized <= nsts.result;
            out_r.last       <= last_r && (gap == COUNT_W'(1));
            out_valid_r      <= 1'b1;
            // channel leaving the window of the next result
            if (drop_old) begin
              wsum_r  <= wsum_r - {{(WSUM_W-SQ_W){1'b0}}, sq_rd};
              terms_r <= terms_r - 6'd1;
            end
            emt_r   <= emt_r + COUNT_W'(1);
            state_r <= last_r ? S_DECIDE : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WINDOW_SIZE: ws_r    <= cfg_wdata[4:0];
          REG_BIAS_K:      bias_r  <= cfg_wdata[23:0];
          REG_ALPHA:       alpha_r <= cfg_wdata;
          REG_BETA:        beta_r  <= cfg_wdata[15:0];
          default:         ;
        endcase
        if (cfg_index <= REG_BETA) begin
          wsum_r  <= '0;
          arr_r   <= '0;
          emt_r   <= '0;
          terms_r <= '0;
        end
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gap <= COUNT_W'(MAX_OUT))
    else $error("pending results exceed the window");

  a_terms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    terms_r < 6'(RING_DEPTH))
    else $error("window term count overran the ring");

  a_norm_start: assert property (@(posedge clk) disable iff (!rst_n)
    nreq.start |-> !nsts.busy)
    else $error("power unit started while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    smp_rd |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");
endmodule
`default_nettype wire
